/* rtl/cda_pkg.sv */
`timescale 1ns / 1ps
// cda_pkg: types, constants and digit helpers for the clock display with alarm
// no dependencies; used by cda_out_if and all modules of the block

package cda_pkg;

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 16;
    localparam int DIGIT_W = 4;
    localparam int SEG_W   = 8;
    localparam int SCAN_W  = 2;

    localparam logic [HOUR_W-1:0] HOURS_PER_DAY = HOUR_W'(24);
    localparam logic [HOUR_W-1:0] HALF_DAY      = HOUR_W'(12);
    localparam logic [MIN_W-1:0]  MINS_PER_HOUR = MIN_W'(60);
    localparam logic [SEG_W-1:0]  SEG_DP        = 8'h80;

    typedef enum logic [1:0] {
        CFG_WAKE_HOUR        = 2'd0,
        CFG_WAKE_MINUTE      = 2'd1,
        CFG_ALARM_TICKS      = 2'd2,
        CFG_TICKS_PER_MINUTE = 2'd3
    } t_cfg_idx;

    typedef enum logic [SCAN_W-1:0] {
        SCAN_MIN_UNITS  = 2'd0,
        SCAN_MIN_TENS   = 2'd1,
        SCAN_HOUR_UNITS = 2'd2,
        SCAN_HOUR_TENS  = 2'd3
    } t_scan;

    typedef struct packed {
        logic [HOUR_W-1:0] wake_hour;
        logic [MIN_W-1:0]  wake_minute;
        logic [TICK_W-1:0] alarm_ticks;
        logic [TICK_W-1:0] ticks_per_minute;
    } t_cfg;

    typedef struct packed {
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic              fmt_24h;
        t_scan             scan;
        logic              led;
    } t_time;

    // gfedcba pattern of one decimal digit
    function automatic logic [6:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h3F;
        endcase
        return s;
    endfunction

    // tens digit in [7:4], units digit in [3:0], for values below 64
    function automatic logic [7:0] split_dec(input logic [MIN_W-1:0] v);
        logic [3:0]       tens;
        logic [MIN_W-1:0] rest;
        tens = 4'd0;
        rest = v;
        if (v >= MIN_W'(60)) begin
            tens = 4'd6;
            rest = v - MIN_W'(60);
        end else if (v >= MIN_W'(50)) begin
            tens = 4'd5;
            rest = v - MIN_W'(50);
        end else if (v >= MIN_W'(40)) begin
            tens = 4'd4;
            rest = v - MIN_W'(40);
        end else if (v >= MIN_W'(30)) begin
            tens = 4'd3;
            rest = v - MIN_W'(30);
        end else if (v >= MIN_W'(20)) begin
            tens = 4'd2;
            rest = v - MIN_W'(20);
        end else if (v >= MIN_W'(10)) begin
            tens = 4'd1;
            rest = v - MIN_W'(10);
        end
        return {tens, rest[3:0]};
    endfunction

endpackage

/* rtl/cda_if.sv */
`timescale 1ns / 1ps
// cda_in_if and cda_out_if: valid/ready channels carrying ticks and display results
// depends on cda_pkg for field widths

interface cda_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface cda_out_if;
    import cda_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit_enable;
    logic [SEG_W-1:0]   segments;
    logic               alarm_led;
    logic [HOUR_W-1:0]  hour_now;
    logic [MIN_W-1:0]   minute_now;
    logic               format_24h;

    modport source (output valid, output digit_enable, output segments, output alarm_led,
                    output hour_now, output minute_now, output format_24h, input ready);
    modport sink   (input valid, input digit_enable, input segments, input alarm_led,
                    input hour_now, input minute_now, input format_24h, output ready);
endinterface

/* rtl/clock_display_alarm_top.sv */
`timescale 1ns / 1ps
// clock_display_alarm_top: multiplexed seven-segment clock with alarm LED and format button
// a tick transaction passes the input register, then the result register
// throughput: one tick per cycle while o_out is not stalled, set by the state update in cda_timekeep
// reset (synchronous, active low): time 00:00, 12h format, LED off, alarm 06:00 for 1000 ticks,
// 25 ticks per minute; both pipeline registers empty
// depends on cda_pkg, cda_if, cda_timekeep and cda_digit

module clock_display_alarm_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [cda_pkg::CFG_W-1:0]  i_cfg_data,
    cda_in_if.sink                     i_in,
    cda_out_if.source                  o_out
);
    import cda_pkg::*;

    t_cfg  r_cfg;
    logic  r_in_valid;
    logic  r_in_button;
    logic  r_out_valid;

    logic [DIGIT_W-1:0] r_digit_enable;
    logic [SEG_W-1:0]   r_segments;
    logic               r_alarm_led;
    logic [HOUR_W-1:0]  r_hour_now;
    logic [MIN_W-1:0]   r_minute_now;
    logic               r_format_24h;

    logic               advance;
    logic               step;
    t_time              cur_time;
    t_time              next_time;
    logic [DIGIT_W-1:0] digit_enable;
    logic [SEG_W-1:0]   segments;

    assign advance = !r_out_valid || o_out.ready;
    assign step    = advance && r_in_valid;
    assign i_in.ready = !r_in_valid || advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wake_hour        <= HOUR_W'(6);
            r_cfg.wake_minute      <= '0;
            r_cfg.alarm_ticks      <= TICK_W'(1000);
            r_cfg.ticks_per_minute <= TICK_W'(25);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WAKE_HOUR:        r_cfg.wake_hour        <= i_cfg_data[HOUR_W-1:0];
                CFG_WAKE_MINUTE:      r_cfg.wake_minute      <= i_cfg_data[MIN_W-1:0];
                CFG_ALARM_TICKS:      r_cfg.alarm_ticks      <= i_cfg_data[TICK_W-1:0];
                CFG_TICKS_PER_MINUTE: r_cfg.ticks_per_minute <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_button <= i_in.button_level;
        end
    end

    cda_timekeep u_timekeep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step),
        .i_button (r_in_button),
        .i_cfg    (r_cfg),
        .o_cur    (cur_time),
        .o_next   (next_time)
    );

    cda_digit u_digit (
        .i_time         (cur_time),
        .o_digit_enable (digit_enable),
        .o_segments     (segments)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_digit_enable <= digit_enable;
            r_segments     <= segments;
            r_alarm_led    <= next_time.led;
            r_hour_now     <= next_time.hour;
            r_minute_now   <= next_time.minute;
            r_format_24h   <= next_time.fmt_24h;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.digit_enable = r_digit_enable;
    assign o_out.segments     = r_segments;
    assign o_out.alarm_led    = r_alarm_led;
    assign o_out.hour_now     = r_hour_now;
    assign o_out.minute_now   = r_minute_now;
    assign o_out.format_24h   = r_format_24h;

    a_onehot_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(r_digit_enable)) else $error("digit select not one-hot");
    a_dp_hour_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_segments[SEG_W-1] == r_digit_enable[SCAN_HOUR_UNITS]))
        else $error("decimal point on wrong digit");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready) else $error("input stalled while empty");
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid) else $error("processed tick produced no result");

endmodule

/* rtl/cda_timekeep.sv */
`timescale 1ns / 1ps
// cda_timekeep: time, scan, alarm timer and format state with next-state logic
// depends on cda_pkg

module cda_timekeep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_button,
    input  cda_pkg::t_cfg i_cfg,
    output cda_pkg::t_time o_cur,
    output cda_pkg::t_time o_next
);
    import cda_pkg::*;

    logic [TICK_W-1:0] r_tick, n_tick;
    logic [MIN_W-1:0]  r_minute, n_minute;
    logic [HOUR_W-1:0] r_hour, n_hour;
    t_scan             r_scan, n_scan;
    logic              r_fmt, n_fmt;
    logic              r_alarm_on, n_alarm_on;
    logic [TICK_W-1:0] r_remaining, n_remaining;
    logic              r_btn_prev, n_btn_prev;

    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] load;
    logic              trig;

    always_comb begin
        n_scan   = t_scan'(r_scan + SCAN_W'(1));
        tick_inc = r_tick + TICK_W'(1);
        n_tick   = tick_inc;
        n_minute = r_minute;
        n_hour   = r_hour;
        if (tick_inc >= i_cfg.ticks_per_minute) begin
            n_tick = '0;
            if (r_minute + MIN_W'(1) >= MINS_PER_HOUR) begin
                n_minute = '0;
                n_hour   = (r_hour + HOUR_W'(1) >= HOURS_PER_DAY) ? '0 : r_hour + HOUR_W'(1);
            end else begin
                n_minute = r_minute + MIN_W'(1);
            end
        end

        // alarm timer: trigger, then count down or switch off in the same tick
        trig        = !r_alarm_on && (n_hour == i_cfg.wake_hour)
                      && (n_minute == i_cfg.wake_minute);
        load        = trig ? i_cfg.alarm_ticks : r_remaining;
        n_alarm_on  = r_alarm_on;
        n_remaining = load;
        if (r_alarm_on || trig) begin
            if (load != '0) begin
                n_alarm_on  = 1'b1;
                n_remaining = load - TICK_W'(1);
            end else begin
                n_alarm_on  = 1'b0;
            end
        end

        n_fmt      = (r_btn_prev && !i_button) ? !r_fmt : r_fmt;
        n_btn_prev = i_button;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_minute    <= '0;
            r_hour      <= '0;
            r_scan      <= SCAN_MIN_UNITS;
            r_fmt       <= 1'b0;
            r_alarm_on  <= 1'b0;
            r_remaining <= '0;
            r_btn_prev  <= 1'b1;
        end else if (i_en) begin
            r_tick      <= n_tick;
            r_minute    <= n_minute;
            r_hour      <= n_hour;
            r_scan      <= n_scan;
            r_fmt       <= n_fmt;
            r_alarm_on  <= n_alarm_on;
            r_remaining <= n_remaining;
            r_btn_prev  <= n_btn_prev;
        end
    end

    assign o_cur  = '{minute: r_minute, hour: r_hour, fmt_24h: r_fmt, scan: r_scan,
                      led: r_alarm_on};
    assign o_next = '{minute: n_minute, hour: n_hour, fmt_24h: n_fmt, scan: n_scan,
                      led: n_alarm_on};

    a_minute_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_minute < MINS_PER_HOUR) else $error("minute out of range");
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour < HOURS_PER_DAY) else $error("hour out of range");
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_scan == t_scan'($past(r_scan) + SCAN_W'(1)))
        else $error("digit scan did not advance");
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_tick) && $stable(r_alarm_on) && $stable(r_remaining))
        else $error("state changed without a tick");

endmodule

/* rtl/cda_digit.sv */
`timescale 1ns / 1ps
// cda_digit: digit select and seven-segment pattern for the scanned digit
// depends on cda_pkg

module cda_digit (
    input  cda_pkg::t_time                  i_time,
    output logic [cda_pkg::DIGIT_W-1:0]     o_digit_enable,
    output logic [cda_pkg::SEG_W-1:0]       o_segments
);
    import cda_pkg::*;

    logic [HOUR_W-1:0] hr_shown;
    logic [7:0]        min_dec;
    logic [7:0]        hr_dec;
    logic [3:0]        digit;

    always_comb begin
        hr_shown = i_time.hour;
        if (!i_time.fmt_24h) begin
            if (i_time.hour == '0) begin
                hr_shown = HALF_DAY;
            end else if (i_time.hour > HALF_DAY) begin
                hr_shown = i_time.hour - HALF_DAY;
            end
        end
        min_dec = split_dec(i_time.minute);
        hr_dec  = split_dec(MIN_W'(hr_shown));

        case (i_time.scan)
            SCAN_MIN_UNITS:  digit = min_dec[3:0];
            SCAN_MIN_TENS:   digit = min_dec[7:4];
            SCAN_HOUR_UNITS: digit = hr_dec[3:0];
            SCAN_HOUR_TENS:  digit = hr_dec[7:4];
            default:         digit = '0;
        endcase

        o_segments = {1'b0, seg_of(digit)};
        if (i_time.scan == SCAN_HOUR_UNITS) begin
            o_segments = o_segments | SEG_DP;
        end
        o_digit_enable = DIGIT_W'(1) << i_time.scan;
    end

endmodule
